>>> design/srsd_pkg.sv
`default_nettype none
// Shared types and constants for the segment range and successive difference block.
// Used by every module of the design; depends on nothing else.
package srsd_pkg;

	localparam int SAMPLE_W = 24;
	localparam int MAG_W    = SAMPLE_W;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = 58;
	localparam int MEAN_W   = 48;
	localparam int PTV_W    = 24;
	localparam int CFG_W    = 8;
	localparam int DIVR_W   = CFG_W;
	localparam int SEG_W    = 2;
	localparam int IDX_W    = 2;
	localparam int STEP_W   = $clog2(SUM_W);

	localparam logic [CFG_W-1:0] BOUNDARY_ONE_RST = 8'd29;
	localparam logic [CFG_W-1:0] BOUNDARY_TWO_RST = 8'd79;
	localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 8'd96;

	localparam logic [IDX_W-1:0] REG_BOUNDARY_ONE = 2'd0;
	localparam logic [IDX_W-1:0] REG_BOUNDARY_TWO = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_LENGTH = 2'd2;

	localparam logic [SEG_W-1:0] SEG_FIRST  = 2'd0;
	localparam logic [SEG_W-1:0] SEG_SECOND = 2'd1;
	localparam logic [SEG_W-1:0] SEG_THIRD  = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] boundary_one;
		logic [CFG_W-1:0] boundary_two;
		logic [CFG_W-1:0] frame_length;
	} cfg_t;

	// One division job handed from the front end to the divider.
	typedef struct packed {
		logic [SEG_W-1:0]  seg;
		logic [PTV_W-1:0]  ptv;
		logic [SUM_W-1:0]  sum;
		logic [DIVR_W-1:0] divisor;
		logic              frame_end;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_wr_t;

	typedef struct packed {
		logic empty;
		job_t job;
	} q_rd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_ACC,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

>>> design/srsd_front.sv
`default_nettype none
// Front end: takes samples, finds their segment, tracks min, max and the squared-difference sum.
// Depends on srsd_pkg; feeds division jobs into srsd_queue.
module srsd_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  srsd_pkg::cfg_t                cfg,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [srsd_pkg::SAMPLE_W-1:0] sample,
	output srsd_pkg::q_wr_t               q_wr,
	input  wire                           q_full
);
	import srsd_pkg::*;

	front_state_t state_q, state_nxt;

	logic [CFG_W-1:0]           sample_position_q;
	logic [SEG_W-1:0]           current_segment_q;
	logic                       segment_fresh_q;
	logic signed [SAMPLE_W-1:0] running_min_q;
	logic signed [SAMPLE_W-1:0] running_max_q;
	logic signed [SAMPLE_W-1:0] previous_sample_q;
	logic [SUM_W-1:0]           square_sum_q;

	logic [MAG_W-1:0]  mag_s1;
	logic              fresh_s1;
	logic [SEG_W-1:0]  seg_s1;
	logic              seg_done_s1;
	logic              frame_done_s1;
	logic [DIVR_W-1:0] div_s1;
	logic [SQ_W-1:0]   sq_s2;

	logic                       accept;
	logic [CFG_W-1:0]           len, e0, e1_raw, e1, seg_start, seg_end, span;
	logic [SEG_W-1:0]           seg;
	logic [CFG_W:0]             next_pos;
	logic                       frame_done, seg_done, fresh;
	logic signed [SAMPLE_W-1:0] s;
	logic signed [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]          diff_abs;
	logic [SUM_W:0]             sum_ext;

	assign s = signed'(sample);

	// Segment ends are clamped so that they never pass each other or the frame end.
	always_comb begin
		len       = (cfg.frame_length == '0) ? CFG_W'(1) : cfg.frame_length;
		e0        = (cfg.boundary_one < len) ? cfg.boundary_one : len;
		e1_raw    = (cfg.boundary_two > e0) ? cfg.boundary_two : e0;
		e1        = (e1_raw > len) ? len : e1_raw;
		if (sample_position_q < e0) begin
			seg = SEG_FIRST;
		end else if (sample_position_q < e1) begin
			seg = SEG_SECOND;
		end else begin
			seg = SEG_THIRD;
		end
		case (seg)
			SEG_FIRST: begin
				seg_start = '0;
				seg_end   = e0;
			end
			SEG_SECOND: begin
				seg_start = e0;
				seg_end   = e1;
			end
			default: begin
				seg_start = e1;
				seg_end   = len;
			end
		endcase
		next_pos   = {1'b0, sample_position_q} + (CFG_W+1)'(1);
		frame_done = next_pos >= {1'b0, len};
		seg_done   = frame_done || (next_pos >= {1'b0, seg_end});
		span       = seg_end - seg_start;
		fresh      = segment_fresh_q || (seg != current_segment_q);
		diff       = {s[SAMPLE_W-1], s} - {previous_sample_q[SAMPLE_W-1], previous_sample_q};
		diff_abs   = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
		sum_ext    = {1'b0, square_sum_q} + (SUM_W+1)'(sq_s2);
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			F_IDLE:  if (in_valid) state_nxt = F_MUL;
			F_MUL:   state_nxt = F_ACC;
			F_ACC:   state_nxt = seg_done_s1 ? F_PUSH : F_IDLE;
			F_PUSH:  if (!q_full) state_nxt = F_IDLE;
			default: state_nxt = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready             = (state_q == F_IDLE);
		q_wr.push            = (state_q == F_PUSH) && !q_full;
		q_wr.job.seg         = seg_s1;
		q_wr.job.ptv         = PTV_W'(running_max_q - running_min_q);
		q_wr.job.sum         = square_sum_q;
		q_wr.job.divisor     = div_s1;
		q_wr.job.frame_end   = frame_done_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= F_IDLE;
			sample_position_q <= '0;
			current_segment_q <= SEG_FIRST;
			segment_fresh_q   <= 1'b1;
			running_min_q     <= '0;
			running_max_q     <= '0;
			previous_sample_q <= '0;
			square_sum_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				previous_sample_q <= s;
				segment_fresh_q   <= seg_done;
				if (fresh || s < running_min_q) running_min_q <= s;
				if (fresh || s > running_max_q) running_max_q <= s;
				if (frame_done) begin
					sample_position_q <= '0;
					current_segment_q <= SEG_FIRST;
				end else begin
					sample_position_q <= next_pos[CFG_W-1:0];
					current_segment_q <= seg_done ? (seg + SEG_W'(1)) : seg;
				end
			end
			if (state_q == F_ACC) begin
				if (fresh_s1) begin
					square_sum_q <= '0;
				end else if (sum_ext[SUM_W]) begin
					square_sum_q <= '1;
				end else begin
					square_sum_q <= sum_ext[SUM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1        <= diff_abs[MAG_W-1:0];
			fresh_s1      <= fresh;
			seg_s1        <= seg;
			seg_done_s1   <= seg_done;
			frame_done_s1 <= frame_done;
			div_s1        <= (span == '0) ? DIVR_W'(1) : span;
		end
		if (state_q == F_MUL) begin
			sq_s2 <= mag_s1 * mag_s1;
		end
	end

endmodule
`default_nettype wire

>>> design/srsd_queue.sv
`default_nettype none
// Two-entry job queue between the front end and the divider.
// Depends on srsd_pkg.
module srsd_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  srsd_pkg::q_wr_t q_wr,
	output logic            full,
	input  wire             pop,
	output srsd_pkg::q_rd_t q_rd
);
	import srsd_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full       = (count_q == 2'd2);
	assign q_rd.empty = (count_q == 2'd0);
	assign q_rd.job   = entry_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && !q_rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= q_wr.job;
	end

endmodule
`default_nettype wire

>>> design/srsd_back.sv
`default_nettype none
// Back end: bit-serial restoring divider for the mean squared difference, plus the result register.
// Depends on srsd_pkg; takes jobs from srsd_queue.
module srsd_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  srsd_pkg::q_rd_t             q_rd,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [srsd_pkg::SEG_W-1:0]  segment_index,
	output logic [srsd_pkg::PTV_W-1:0]  peak_to_valley,
	output logic [srsd_pkg::MEAN_W-1:0] mean_sq_diff,
	output logic                        frame_end
);
	import srsd_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	back_state_t state_q, state_nxt;

	logic [SUM_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divisor_q;
	logic [STEP_W-1:0] step_q;
	logic [SEG_W-1:0]  seg_q;
	logic [PTV_W-1:0]  ptv_q;
	logic              frame_end_q;
	logic              out_valid_q;

	logic [DIVR_W:0]   trial;
	logic              fits;
	logic              load_out;
	logic [MEAN_W-1:0] mean_sat;

	always_comb begin
		trial    = {rem_q, quo_q[SUM_W-1]};
		fits     = trial >= {1'b0, divisor_q};
		mean_sat = (|quo_q[SUM_W-1:MEAN_W]) ? '1 : quo_q[MEAN_W-1:0];
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE:  if (!q_rd.empty) state_nxt = B_RUN;
			B_RUN:   if (step_q == LAST_STEP) state_nxt = B_DONE;
			B_DONE:  if (!out_valid_q || out_ready) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == B_IDLE) && !q_rd.empty;
		load_out = (state_q == B_DONE) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				step_q <= '0;
			end else if (state_q == B_RUN) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q       <= q_rd.job.sum;
			rem_q       <= '0;
			divisor_q   <= q_rd.job.divisor;
			seg_q       <= q_rd.job.seg;
			ptv_q       <= q_rd.job.ptv;
			frame_end_q <= q_rd.job.frame_end;
		end else if (state_q == B_RUN) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? DIVR_W'(trial - {1'b0, divisor_q}) : trial[DIVR_W-1:0];
		end
		if (load_out) begin
			segment_index  <= seg_q;
			peak_to_valley <= ptv_q;
			mean_sq_diff   <= mean_sat;
			frame_end      <= frame_end_q;
		end
	end

endmodule
`default_nettype wire

>>> design/segment_range_and_successive_diff_stats.sv
`default_nettype none
// A sample that closes a segment passes the front end states (multiply, accumulate, push),
// the queue, the 58 divider steps and the output register before its result shows.
// The front end takes no new sample word until it is through with the last one; the divider
// works one job at a time, with up to two further jobs waiting in the queue.
// Reset (arst_n low, asynchronous) clears all control state and loads the configuration
// registers with 29, 79 and 96; no clearing pass follows.
//
// Depends on srsd_pkg, srsd_front, srsd_queue and srsd_back.
module segment_range_and_successive_diff_stats (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_write,
	input  wire  [srsd_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [srsd_pkg::CFG_W-1:0]    cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [srsd_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [srsd_pkg::SEG_W-1:0]    segment_index,
	output logic [srsd_pkg::PTV_W-1:0]    peak_to_valley,
	output logic [srsd_pkg::MEAN_W-1:0]   mean_sq_diff,
	output logic                          frame_end
);
	import srsd_pkg::*;

	// The three configuration registers. They must be written only while the block is quiet,
	// so the front end reads them directly; unchecked. A write to an unused index is dropped.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boundary_one <= BOUNDARY_ONE_RST;
			cfg_q.boundary_two <= BOUNDARY_TWO_RST;
			cfg_q.frame_length <= FRAME_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BOUNDARY_ONE: cfg_q.boundary_one <= cfg_data;
				REG_BOUNDARY_TWO: cfg_q.boundary_two <= cfg_data;
				REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end classifies each sample by its frame position, keeps the running
	// minimum, maximum and the saturating sum of squared neighbor differences, and on the
	// last sample of a segment hands the sum, the range and the segment length onward.
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	srsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.q_wr     (q_wr),
		.q_full   (q_full)
	);

	// The queue lets the front end keep taking samples while a division is under way.
	srsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.q_rd   (q_rd)
	);

	// The back end divides the sum by the segment length one quotient bit per cycle,
	// saturates the quotient to 48 bits and holds the finished word in its output register.
	srsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_rd           (q_rd),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_index  (segment_index),
		.peak_to_valley (peak_to_valley),
		.mean_sq_diff   (mean_sq_diff),
		.frame_end      (frame_end)
	);

endmodule
`default_nettype wire
